// ===== hdl/nbts_pkg.sv =====
// Shared types and constants for the negabinary tree broadcast schedule block.
package nbts_pkg;

   localparam int RANK_W  = 16;              // rank and peer width
   localparam int SIZE_W  = RANK_W + 1;      // communicator size width
   localparam int SLOG_W  = 5;               // holds 0..RANK_W
   localparam int STEP_W  = 4;
   localparam int DIV_CNT_W = 4;             // counts RANK_W dividend bits

   localparam logic [RANK_W-1:0] NB_ODD_MASK = 16'hAAAA;
   localparam logic [SIZE_W-1:0] SIZE_MAX    = 17'h10000;

   localparam logic [1:0] ACT_IDLE = 2'd0;
   localparam logic [1:0] ACT_SEND = 2'd1;
   localparam logic [1:0] ACT_RECV = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_STEP_A,
      ST_STEP_B
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic prep1;
      logic prep2;
      logic prep3;
      logic step_a;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

// ===== hdl/nbts_ctrl.sv =====
// Sequencer for the schedule block: remainder passes, setup and per-step timing.
module nbts_ctrl import nbts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == '1) begin
               state_in = ST_PREP1;
            end
         end
         ST_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = ST_PREP2;
         end
         ST_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in  = ST_PREP3;
         end
         ST_PREP3: begin
            cmd.prep3 = 1'b1;
            state_in  = ST_STEP_A;
         end
         ST_STEP_A: begin
            cmd.step_a = 1'b1;
            state_in   = ST_STEP_B;
         end
         ST_STEP_B: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.last ? ST_IDLE : ST_STEP_A;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

`ifndef NO_ASSERTIONS
   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && status.last) |=> (state_ff == ST_IDLE))
      else $error("schedule did not end after last step");

   a_div_starts_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && $past(state_ff) == ST_IDLE) |-> (div_cnt_ff == '0))
      else $error("remainder pass started with stale count");

   a_out_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP1) |-> ($past(div_cnt_ff) == '1))
      else $error("setup entered before all dividend bits done");
`endif

endmodule

// ===== hdl/nbts_dp.sv =====
// Datapath: size register, bit-serial remainders, negabinary step arithmetic.
module nbts_dp import nbts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [SIZE_W-1:0]   csr_write_data,
   input  logic [RANK_W-1:0]   req_node_rank,
   input  logic [RANK_W-1:0]   req_root_rank,
   input  cmd_type             cmd,
   output status_type          status,
   output logic [1:0]          rsp_action,
   output logic [RANK_W-1:0]   rsp_peer_rank,
   output logic [STEP_W-1:0]   rsp_step_index,
   output logic                rsp_last_step
);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SLOG_W-1:0] s_ff, s_in;
   logic [RANK_W-1:0] rank_sh_ff, root_sh_ff;
   logic [RANK_W-1:0] rank_rem_ff, root_rem_ff;
   logic [SIZE_W-1:0] smr_ff;
   logic              have_ff, have_in;
   logic [RANK_W-1:0] vrank_ff;
   logic [RANK_W-1:0] nb_ff;
   logic [RANK_W-1:0] wmask_ff;
   logic [SLOG_W-1:0] k_ff;
   logic [RANK_W-1:0] vq_ff;
   logic              big_ff;
   logic [1:0]        act_ff;
   logic [STEP_W-1:0] step_ff;
   logic              last_ff;
   logic [1:0]        act_out_ff;
   logic [RANK_W-1:0] peer_out_ff;
   logic [STEP_W-1:0] step_out_ff;
   logic              last_out_ff;

   logic [SIZE_W-1:0] size_m1;
   logic [SIZE_W-1:0] rank_try, root_try;
   logic [RANK_W-1:0] rank_rem_in, root_rem_in;
   logic [SIZE_W-1:0] diff;
   logic [SIZE_W-1:0] vrank_wrap;
   logic [RANK_W-1:0] mask_k;
   logic [RANK_W-1:0] vq;
   logic [RANK_W-1:0] masked;
   logic              big;
   logic [1:0]        act;
   logic [SLOG_W-1:0] step_full;
   logic [SIZE_W-1:0] q_sub, q_add;
   logic [RANK_W-1:0] peer;

   // size register, clamped to 1..65536
   always_comb begin
      size_in = size_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            size_in = SIZE_W'(1);
         end else if (csr_write_data > SIZE_MAX) begin
            size_in = SIZE_MAX;
         end else begin
            size_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   // s = ceil(log2 size): bit length of size-1
   always_comb begin
      size_m1 = size_ff - 1'b1;
      s_in    = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (size_m1[i]) begin
            s_in = SLOG_W'(i + 1);
         end
      end
   end

   // restoring remainder, one dividend bit per cycle, both ranks in parallel
   always_comb begin
      rank_try    = {rank_rem_ff, rank_sh_ff[RANK_W-1]};
      root_try    = {root_rem_ff, root_sh_ff[RANK_W-1]};
      rank_rem_in = (rank_try >= size_ff) ? RANK_W'(rank_try - size_ff) : RANK_W'(rank_try);
      root_rem_in = (root_try >= size_ff) ? RANK_W'(root_try - size_ff) : RANK_W'(root_try);
   end

   // virtual rank
   assign diff       = {1'b0, rank_rem_ff} - {1'b0, root_rem_ff};
   assign vrank_wrap = {1'b0, rank_rem_ff} + smr_ff;

   // per step arithmetic
   always_comb begin
      mask_k    = RANK_W'(~({SIZE_W{1'b1}} << k_ff));
      vq        = ((NB_ODD_MASK ^ (nb_ff ^ mask_k)) - NB_ODD_MASK) & wmask_ff;
      big       = ({1'b0, vq} >= size_ff) || (s_ff == '0);
      masked    = nb_ff & mask_k;
      have_in   = have_ff;
      if (big) begin
         act = ACT_IDLE;
      end else if (have_ff) begin
         act = ACT_SEND;
      end else if (masked == '0 || masked == mask_k) begin
         act     = ACT_RECV;
         have_in = 1'b1;
      end else begin
         act = ACT_IDLE;
      end
      step_full = s_ff - k_ff;
   end

   // real peer: vq + root mod size, using size - root to pick the branch
   always_comb begin
      q_sub = {1'b0, vq_ff} - smr_ff;
      q_add = {1'b0, vq_ff} + {1'b0, root_rem_ff};
      if (big_ff) begin
         peer = '0;
      end else if ({1'b0, vq_ff} >= smr_ff) begin
         peer = RANK_W'(q_sub);
      end else begin
         peer = RANK_W'(q_add);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff        <= s_in;
         rank_sh_ff  <= req_node_rank;
         root_sh_ff  <= req_root_rank;
         rank_rem_ff <= '0;
         root_rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rank_rem_ff <= rank_rem_in;
         root_rem_ff <= root_rem_in;
         rank_sh_ff  <= {rank_sh_ff[RANK_W-2:0], 1'b0};
         root_sh_ff  <= {root_sh_ff[RANK_W-2:0], 1'b0};
      end
      if (cmd.prep1) begin
         smr_ff   <= size_ff - {1'b0, root_rem_ff};
         have_ff  <= (rank_rem_ff == root_rem_ff);
         wmask_ff <= RANK_W'(~({SIZE_W{1'b1}} << s_ff));
      end
      if (cmd.prep2) begin
         vrank_ff <= diff[SIZE_W-1] ? RANK_W'(vrank_wrap) : RANK_W'(diff);
      end
      if (cmd.prep3) begin
         nb_ff <= ((NB_ODD_MASK + vrank_ff) ^ NB_ODD_MASK) & wmask_ff;
         k_ff  <= s_ff;
      end
      if (cmd.step_a) begin
         vq_ff   <= vq;
         big_ff  <= big;
         act_ff  <= act;
         have_ff <= have_in;
         step_ff <= STEP_W'(step_full);
         last_ff <= (k_ff <= SLOG_W'(1));
         if (k_ff != '0) begin
            k_ff <= k_ff - 1'b1;
         end
      end
      if (cmd.out_load) begin
         act_out_ff  <= act_ff;
         peer_out_ff <= peer;
         step_out_ff <= step_ff;
         last_out_ff <= last_ff;
      end
   end

   assign status.last    = last_ff;
   assign rsp_action     = act_out_ff;
   assign rsp_peer_rank  = peer_out_ff;
   assign rsp_step_index = step_out_ff;
   assign rsp_last_step  = last_out_ff;

endmodule

// ===== hdl/negabinary_tree_bcast_schedule.sv =====
// Top level of the negabinary tree broadcast schedule generator.
//
// Usage:
//  - csr_write_enable/csr_write_data load the communicator size (0 counts
//    as 1, anything above 65536 as 65536). Write only while no item is open.
//  - req_* takes one item (node rank, root rank). Ranks are reduced mod size.
//  - rsp_* gives n = max(s,1) result items per request, s = ceil(log2 size),
//    in step order; rsp_last_step marks the final one.
// Sequence, receiver always ready:
//  - bit-serial remainder over all 16 rank bits (one rank bit per cycle),
//    then setup in PREP1, PREP2 and PREP3, then per result a negabinary
//    step, then peer wrap into the result register.
//  - req_ready returns once the last result is loaded.
// Stall: a held result freezes the step sequencer; the last result may sit
//   in the output register while the next item is already accepted.
// Reset (synchronous, active high): size back to 1, sequencer idle,
//   no result valid.
module negabinary_tree_bcast_schedule import nbts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [RANK_W-1:0]   req_node_rank,
   input  logic [RANK_W-1:0]   req_root_rank,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_action,
   output logic [RANK_W-1:0]   rsp_peer_rank,
   output logic [STEP_W-1:0]   rsp_step_index,
   output logic                rsp_last_step,
   input  logic                csr_write_enable,
   input  logic [SIZE_W-1:0]   csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing only; all arithmetic lives in the datapath
   nbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nbts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_node_rank    (req_node_rank),
      .req_root_rank    (req_root_rank),
      .cmd              (cmd),
      .status           (status),
      .rsp_action       (rsp_action),
      .rsp_peer_rank    (rsp_peer_rank),
      .rsp_step_index   (rsp_step_index),
      .rsp_last_step    (rsp_last_step)
   );

endmodule

// ===== bench/nbts_checker.sv =====
// Checker for the negabinary tree broadcast schedule block: predicts and compares results.
`timescale 1ns / 100ps

module nbts_checker import nbts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [RANK_W-1:0]   req_node_rank,
   input  logic [RANK_W-1:0]   req_root_rank,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_action,
   input  logic [RANK_W-1:0]   rsp_peer_rank,
   input  logic [STEP_W-1:0]   rsp_step_index,
   input  logic                rsp_last_step,
   input  logic                csr_write_enable,
   input  logic [SIZE_W-1:0]   csr_write_data,
   output int                  mismatch_count,
   output int                  results_due
);

   localparam int unsigned NEG_ODD = 32'hAAAA_AAAA;   // odd-weight bits for negabinary

   typedef struct packed {
      logic [1:0]        action;
      logic [RANK_W-1:0] peer;
      logic [STEP_W-1:0] step;
      logic              last;
   } sched_step_type;

   sched_step_type    expected_steps[$];
   logic [SIZE_W-1:0] comm_size_copy;

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   function automatic void add_step(input logic [1:0] act, input int unsigned peer,
                                    input int unsigned step, input bit last);
      sched_step_type rec;
      rec.action = act;
      rec.peer   = RANK_W'(peer);
      rec.step   = STEP_W'(step);
      rec.last   = last;
      expected_steps.push_back(rec);
   endfunction

   // Full schedule of one node for the size now in force.
   function automatic void build_schedule(input logic [RANK_W-1:0] node,
                                          input logic [RANK_W-1:0] root_in);
      int unsigned size, bits, rank, root, vrank, nb, wmask, m, vq, q, masked;
      bit holds;
      size = comm_size_copy;
      if (size == 0) size = 1;
      if (size > SIZE_MAX) size = SIZE_MAX;
      bits = 0;
      while ((1 << bits) < size) bits++;
      rank = node % size;
      root = root_in % size;
      if (bits == 0) begin
         // lone node: one idle step
         add_step(ACT_IDLE, 0, 0, 1'b1);
         return;
      end
      wmask = (1 << bits) - 1;
      vrank = (rank + size - root) % size;
      nb    = ((NEG_ODD + vrank) ^ NEG_ODD) & wmask;
      holds = (rank == root);
      for (int k = bits; k >= 1; k--) begin
         m  = (1 << k) - 1;
         vq = ((NEG_ODD ^ (nb ^ m)) - NEG_ODD) & wmask;
         if (vq >= size) begin
            // partner falls outside the communicator
            add_step(ACT_IDLE, 0, bits - k, k == 1);
            continue;
         end
         q = vq + root;
         if (q >= size) q -= size;
         if (holds)
            add_step(ACT_SEND, q, bits - k, k == 1);
         else begin
            masked = nb & m;
            if (masked == 0 || masked == m) begin
               add_step(ACT_RECV, q, bits - k, k == 1);
               holds = 1'b1;
            end else
               add_step(ACT_IDLE, q, bits - k, k == 1);
         end
      end
   endfunction

   always @(posedge clock) begin
      sched_step_type want;
      if (reset) begin
         comm_size_copy = SIZE_W'(1);
         mismatch_count = 0;
         expected_steps.delete();
      end else begin
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0)
               flag_mismatch("unexpected result, action", rsp_action, 0);
            else begin
               want = expected_steps.pop_front();
               if (rsp_action !== want.action)
                  flag_mismatch("action", rsp_action, want.action);
               if (rsp_peer_rank !== want.peer)
                  flag_mismatch("peer_rank", rsp_peer_rank, want.peer);
               if (rsp_step_index !== want.step)
                  flag_mismatch("step_index", rsp_step_index, want.step);
               if (rsp_last_step !== want.last)
                  flag_mismatch("last_step", rsp_last_step, want.last);
            end
         end
         if (req_valid && req_ready)
            build_schedule(req_node_rank, req_root_rank);
         if (csr_write_enable)
            comm_size_copy = csr_write_data;
      end
      results_due <= expected_steps.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the negabinary tree broadcast schedule block: stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import nbts_pkg::*;

   // Longest run of cycles with no item moving on either channel before we
   // call the block hung. A request passes the remainder and setup states before
   // its first result, then a step and a load per result; random stalls add to that.
   localparam int STALL_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 60;    // quiet time after the last result
   localparam int IDLE_PERCENT  = 13;
   localparam int RAND_PHASES   = 20;
   localparam int PHASE_ITEMS   = 25;
   localparam int CALM_PHASES   = 4;     // opening phases run without any idling
   localparam int HOLD_PHASE    = 10;    // phase where the sender waits for a drain

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [RANK_W-1:0]   req_node_rank    = '0;
   logic [RANK_W-1:0]   req_root_rank    = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [1:0]          rsp_action;
   logic [RANK_W-1:0]   rsp_peer_rank;
   logic [STEP_W-1:0]   rsp_step_index;
   logic                rsp_last_step;
   logic                csr_write_enable = 1'b0;
   logic [SIZE_W-1:0]   csr_write_data   = '0;

   int          mismatch_count;
   int          results_due;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;          // when set, neither side idles
   int unsigned nodes_in_use = 1;     // effective size, for picking ranks

   negabinary_tree_bcast_schedule i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_node_rank    (req_node_rank),
      .req_root_rank    (req_root_rank),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_peer_rank    (rsp_peer_rank),
      .rsp_step_index   (rsp_step_index),
      .rsp_last_step    (rsp_last_step),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   nbts_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_node_rank    (req_node_rank),
      .req_root_rank    (req_root_rank),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_peer_rank    (rsp_peer_rank),
      .rsp_step_index   (rsp_step_index),
      .rsp_last_step    (rsp_last_step),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .results_due      (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: ready drops about 13 percent of the time unless calm.
   always @(posedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

   // Watchdog: any accepted item on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Offer one request and hold it until taken. Random gaps go in front.
   // Returns at the edge where the item was accepted.
   task automatic send_request(input logic [RANK_W-1:0] node,
                               input logic [RANK_W-1:0] root);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_node_rank <= node;
      req_root_rank <= root;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off the sender until every predicted step has come out.
   // results_due is updated with a nonblocking write, so the value read here
   // is the one left by the previous edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Size writes only happen with the block empty.
   task automatic set_comm_size(input logic [SIZE_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (value == 0)
         nodes_in_use = 1;
      else if (value > SIZE_MAX)
         nodes_in_use = SIZE_MAX;
      else
         nodes_in_use = value;
   endtask

   // Mostly valid ranks; now and then a full 16-bit value that may need to wrap.
   function automatic logic [RANK_W-1:0] pick_rank();
      if ($urandom_range(99) < 85)
         return RANK_W'($urandom_range(nodes_in_use - 1));
      return RANK_W'($urandom_range(16'hFFFF));
   endfunction

   // Small sizes dominate; powers of two and clamped sizes show up too.
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned p;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return SIZE_W'($urandom_range(40, 2));
         5:             return SIZE_W'($urandom_range(1024, 41));
         6: begin
            p = 1 << $urandom_range(16, 1);
            return SIZE_W'(p + $urandom_range(2) - 1);
         end
         7:             return SIZE_W'($urandom_range(65536, 1025));
         8:             return SIZE_W'($urandom_range(1));
         default:       return SIZE_W'($urandom_range(131071, 65537));
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // size 1 straight out of reset: a lone node, also with ranks to wrap
      send_request(16'h0000, 16'h0000);
      send_request(16'hFFFF, 16'h1234);
      // size 0 counts as one node
      set_comm_size(17'd0);
      send_request(16'h0005, 16'h0007);
      // two nodes: root sends, the other receives
      set_comm_size(17'd2);
      send_request(16'h0000, 16'h0000);
      send_request(16'h0001, 16'h0000);
      send_request(16'h0000, 16'h0001);
      // three nodes: some partners land past the end of the communicator
      set_comm_size(17'd3);
      send_request(16'h0002, 16'h0000);
      send_request(16'h0001, 16'h0002);
      // five nodes with ranks above the size
      set_comm_size(17'd5);
      send_request(16'h0004, 16'h0001);
      send_request(16'h0009, 16'h000C);
      // largest size: sixteen steps, rank extremes and alternating bits
      set_comm_size(SIZE_MAX);
      send_request(16'h0000, 16'h0000);
      send_request(16'hFFFF, 16'h0000);
      send_request(16'h0000, 16'hFFFF);
      send_request(16'hAAAA, 16'h5555);
      send_request(16'h5555, 16'hAAAA);
      // sizes past the limit are clamped to it
      set_comm_size({SIZE_W{1'b1}});
      send_request(16'h1234, 16'hFFFF);
      set_comm_size(SIZE_MAX + 1);
      send_request(16'hFFFF, 16'hFFFF);
      // six nodes: the root and a node that receives and then sends
      set_comm_size(17'd6);
      send_request(16'h0003, 16'h0003);
      send_request(16'h0005, 16'h0002);

      // ---- random part ----
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         set_comm_size(pick_size());
         calm = (phase < CALM_PHASES);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // once, let everything drain in the middle of a stream
            if (phase == HOLD_PHASE && n == PHASE_ITEMS / 2)
               wait_drained();
            send_request(pick_rank(), pick_rank());
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/nbts_pkg.sv
hdl/nbts_ctrl.sv
hdl/nbts_dp.sv
hdl/negabinary_tree_bcast_schedule.sv
bench/nbts_checker.sv
bench/testbench.sv
